FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file ptl_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// Types, codes and fixed widths of the paged translation block.
// ----------------------------------------------------------------------------
package ptl_pkg;

    localparam int OP_W      = 2;
    localparam int VA_W      = 16;
    localparam int PID_W     = 2;
    localparam int WBYTE_W   = 8;
    localparam int ST_W      = 3;
    localparam int PA_W      = 8;
    localparam int PAGE_W    = 6;
    localparam int FRAME_W   = 6;
    localparam int FN_W      = 4;
    localparam int CNT_W     = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CFG   = 7;

    localparam logic [OP_W-1:0] OP_READ    = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_EXEC    = 2'd2;
    localparam logic [OP_W-1:0] OP_INVALID = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_OOB      = 3'd1;
    localparam logic [ST_W-1:0] ST_PROC     = 3'd2;
    localparam logic [ST_W-1:0] ST_RD_DENY  = 3'd3;
    localparam logic [ST_W-1:0] ST_WR_DENY  = 3'd4;
    localparam logic [ST_W-1:0] ST_EX_DENY  = 3'd5;
    localparam logic [ST_W-1:0] ST_INVALID  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_READABLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXECUTABLE = 3'd6;

    typedef struct packed {
        logic capture;
        logic mul;
        logic qd;
        logic divide;
        logic deny;
        logic hit_rd;
        logic hit_load;
        logic alloc;
        logic scan_init;
        logic scan_step;
        logic evict;
        logic update;
    } ptl_cmd_t;

    typedef struct packed {
        logic oob;
        logic denied;
        logic hit;
        logic frame_free;
        logic scan_done;
    } ptl_stat_t;

endpackage

FILE: rtl/core/paged_translation_lfu_top.sv
// ----------------------------------------------------------------------------
// paged_translation_lfu_top
// Demand-paged address translation with least frequently used replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; opcode,
// virtual_address and process_id are sampled then; write_byte is not. busy stays
// high until the result is out. The result is shown for one cycle with
// done high; the receiver cannot stall, so it must take it in that cycle.
// After the multiply, quotient and divide steps, the check step ends an
// out-of-bounds or denied request; else a hit reads its page entry, a fault
// with a free frame takes it, and a fault with none runs the victim scan, one
// page entry per cycle from the single-port page store, then evicts; all
// three end with an update step. A new request may be issued in the cycle
// done is high. Config registers (index 0..6: process 0..3 masks, readable,
// writable, executable) are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle, as the block does not enforce this.
// Reset sets all masks to ones, unloads every page and frees every frame;
// it takes effect at once, with no clearing pass.
// ----------------------------------------------------------------------------
module paged_translation_lfu_top #(
    parameter int PAGE_BYTES    = 16,
    parameter int NUM_PAGES     = 64,
    parameter int NUM_FRAMES    = 16,
    parameter int NUM_PROCESSES = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ptl_pkg::OP_W-1:0]          opcode,
    input  logic [ptl_pkg::VA_W-1:0]          virtual_address,
    input  logic [ptl_pkg::PID_W-1:0]         process_id,
    input  logic [ptl_pkg::WBYTE_W-1:0]       write_byte,
    input  logic                              cfg_we,
    input  logic [ptl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptl_pkg::CFG_W-1:0]         cfg_data,
    output logic                              done,
    output logic [ptl_pkg::ST_W-1:0]          status,
    output logic [ptl_pkg::PA_W-1:0]          physical_address,
    output logic                              page_fault,
    output logic                              replaced,
    output logic [ptl_pkg::PAGE_W-1:0]        victim_page,
    output logic                              writeback,
    output logic [ptl_pkg::FN_W-1:0]          frame_number
);
    import ptl_pkg::*;

    ptl_cmd_t  cmd;
    ptl_stat_t stat;

    // write_byte carries data only; translation does not look at it

    ptl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ptl_datapath #(
        .PAGE_BYTES    (PAGE_BYTES),
        .NUM_PAGES     (NUM_PAGES),
        .NUM_FRAMES    (NUM_FRAMES),
        .NUM_PROCESSES (NUM_PROCESSES)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .opcode           (opcode),
        .virtual_address  (virtual_address),
        .process_id       (process_id),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .status           (status),
        .physical_address (physical_address),
        .page_fault       (page_fault),
        .replaced         (replaced),
        .victim_page      (victim_page),
        .writeback        (writeback),
        .frame_number     (frame_number)
    );

endmodule

FILE: rtl/core/ptl_ctrl.sv
// ----------------------------------------------------------------------------
// ptl_ctrl
// Sequencer for one translation request: split, check, fault handling, update.
// ----------------------------------------------------------------------------
module ptl_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ptl_pkg::ptl_stat_t   stat,
    output ptl_pkg::ptl_cmd_t    cmd
);
    import ptl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_QD    = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_HIT   = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_EVICT = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_QD;
            end
            S_QD:
            begin
                cmd.qd     = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.divide = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.oob || stat.denied)
                begin
                    cmd.deny   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.hit)
                begin
                    cmd.hit_rd = 1'b1;
                    state_next = S_HIT;
                end
                else if (stat.frame_free)
                begin
                    cmd.alloc  = 1'b1;
                    state_next = S_UPD;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_HIT:
            begin
                cmd.hit_load = 1'b1;
                state_next   = S_UPD;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: rtl/core/ptl_datapath.sv
// ----------------------------------------------------------------------------
// ptl_datapath
// Page tables, frame allocation, LFU victim scan and result registers.
// ----------------------------------------------------------------------------
module ptl_datapath #(
    parameter int PAGE_BYTES    = 16,
    parameter int NUM_PAGES     = 64,
    parameter int NUM_FRAMES    = 16,
    parameter int NUM_PROCESSES = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ptl_pkg::ptl_cmd_t                 cmd,
    output ptl_pkg::ptl_stat_t                stat,
    input  logic [ptl_pkg::OP_W-1:0]          opcode,
    input  logic [ptl_pkg::VA_W-1:0]          virtual_address,
    input  logic [ptl_pkg::PID_W-1:0]         process_id,
    input  logic                              cfg_we,
    input  logic [ptl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptl_pkg::CFG_W-1:0]         cfg_data,
    output logic                              done,
    output logic [ptl_pkg::ST_W-1:0]          status,
    output logic [ptl_pkg::PA_W-1:0]          physical_address,
    output logic                              page_fault,
    output logic                              replaced,
    output logic [ptl_pkg::PAGE_W-1:0]        victim_page,
    output logic                              writeback,
    output logic [ptl_pkg::FN_W-1:0]          frame_number
);
    import ptl_pkg::*;

    localparam int PG_IW  = $clog2(NUM_PAGES);
    localparam int FR_IW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FC_W   = $clog2(NUM_FRAMES + 1);
    localparam int SC_W   = $clog2(NUM_PAGES + 1);
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int MEM_W  = FR_IW + CNT_W;
    localparam int PROD_W = VA_W + 32;
    localparam int PHYS_W = 20;

    // floor(2^32 / PAGE_BYTES): quotient estimate is low by at most one
    localparam logic [31:0]     RECIP = 32'((64'd1 << 32) / PAGE_BYTES);
    localparam logic [VA_W-1:0] PB16  = VA_W'(PAGE_BYTES);
    localparam logic [18:0]     VSIZE = 19'(PAGE_BYTES * NUM_PAGES);

    // request capture
    logic [OP_W-1:0]   op_reg;
    logic [VA_W-1:0]   va_reg;
    logic [PID_W-1:0]  pid_reg;

    // address split
    logic [PROD_W-1:0] prod_reg;
    logic [VA_W-1:0]   q0_reg;
    logic [VA_W-1:0]   qd_reg;
    logic [PG_IW-1:0]  pg_reg;
    logic [OFF_W-1:0]  off_reg;
    logic              oob_reg;
    logic [VA_W-1:0]   rem0;

    // config and page flags
    logic [CFG_W-1:0]      cfg_reg [NUM_CFG];
    logic [NUM_PAGES-1:0]  loaded_reg;
    logic [NUM_PAGES-1:0]  modified_reg;
    logic [FC_W-1:0]       fill_reg;

    // frame / use count store, one entry per page
    logic [MEM_W-1:0]  mem [NUM_PAGES];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              mem_re;
    logic              mem_we;
    logic [PG_IW-1:0]  mem_raddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic [FR_IW-1:0]  rd_frame;
    logic [CNT_W-1:0]  rd_count;

    // victim scan
    logic [SC_W-1:0]   scan_cnt_reg;
    logic              scan_issue;
    logic              cmp_vld_reg;
    logic [PG_IW-1:0]  cmp_idx_reg;
    logic              any_reg;
    logic [CNT_W-1:0]  best_cnt_reg;
    logic [FR_IW-1:0]  best_frame_reg;
    logic [PG_IW-1:0]  vp_reg;
    logic              take;

    // working page state
    logic [FR_IW-1:0]  frame_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              fault_reg;
    logic              repl_reg;
    logic              wb_reg;
    logic [PG_IW-1:0]  victim_reg;
    logic [FR_IW-1:0]  alloc_frame;
    logic [FR_IW-1:0]  evict_frame;
    logic [CNT_W-1:0]  count_inc;

    // checks
    logic [PAGE_W-1:0] pg_ext;
    logic [CFG_W-1:0]  perm_mask;
    logic              perm_ok;
    logic [ST_W-1:0]   upd_status;
    logic [PHYS_W-1:0] phys_full;
    logic [FRAME_W-1:0] frame_ext;

    // result registers
    logic              done_reg;
    logic [ST_W-1:0]   status_reg;
    logic [PA_W-1:0]   phys_reg;
    logic              page_fault_reg;
    logic              replaced_reg;
    logic [PAGE_W-1:0] victim_page_reg;
    logic              writeback_reg;
    logic [FN_W-1:0]   frame_number_reg;

    assign rem0     = va_reg - qd_reg;
    assign pg_ext   = PAGE_W'(pg_reg);
    assign rd_frame = rd_data_reg[MEM_W-1:CNT_W];
    assign rd_count = rd_data_reg[CNT_W-1:0];

    always_comb
    begin
        case (op_reg)
            OP_READ:  perm_mask = cfg_reg[REG_READABLE];
            OP_WRITE: perm_mask = cfg_reg[REG_WRITABLE];
            default:  perm_mask = cfg_reg[REG_EXECUTABLE];
        endcase
    end

    assign perm_ok = perm_mask[pg_ext];

    always_comb
    begin
        if (op_reg == OP_INVALID)
        begin
            upd_status = ST_INVALID;
        end
        else if (perm_ok)
        begin
            upd_status = ST_OK;
        end
        else
        begin
            case (op_reg)
                OP_READ:  upd_status = ST_RD_DENY;
                OP_WRITE: upd_status = ST_WR_DENY;
                default:  upd_status = ST_EX_DENY;
            endcase
        end
    end

    assign stat.oob        = oob_reg;
    assign stat.denied     = ({1'b0, pid_reg} >= (PID_W + 1)'(NUM_PROCESSES)) ||
                             !cfg_reg[{1'b0, pid_reg}][pg_ext];
    assign stat.hit        = loaded_reg[pg_reg];
    assign stat.frame_free = (fill_reg < FC_W'(NUM_FRAMES));
    assign stat.scan_done  = cmp_vld_reg && (cmp_idx_reg == PG_IW'(NUM_PAGES - 1));

    assign scan_issue  = (scan_cnt_reg < SC_W'(NUM_PAGES));
    assign take        = loaded_reg[cmp_idx_reg] && (!any_reg || rd_count < best_cnt_reg);
    assign alloc_frame = FR_IW'(fill_reg);
    assign evict_frame = any_reg ? best_frame_reg : '0;
    assign count_inc   = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign phys_full   = PHYS_W'(frame_reg) * PHYS_W'(PAGE_BYTES) + PHYS_W'(off_reg);
    assign frame_ext   = FRAME_W'(frame_reg);

    assign mem_re    = cmd.hit_rd || (cmd.scan_step && scan_issue);
    assign mem_raddr = cmd.scan_step ? PG_IW'(scan_cnt_reg) : pg_reg;
    assign mem_we    = cmd.alloc || cmd.evict || (cmd.update && op_reg != OP_INVALID);

    always_comb
    begin
        if (cmd.alloc)
        begin
            mem_wdata = {alloc_frame, {CNT_W{1'b0}}};
        end
        else if (cmd.evict)
        begin
            mem_wdata = {evict_frame, {CNT_W{1'b0}}};
        end
        else
        begin
            mem_wdata = {frame_reg, count_inc};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pg_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= '1;
            end
            loaded_reg   <= '0;
            modified_reg <= '0;
            fill_reg     <= '0;
            done_reg     <= 1'b0;
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            any_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.deny || cmd.update;
            if (cfg_we && cfg_index < CFG_IDX_W'(NUM_CFG))
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            if (cmd.alloc)
            begin
                loaded_reg[pg_reg]   <= 1'b1;
                modified_reg[pg_reg] <= 1'b0;
                fill_reg             <= fill_reg + 1'b1;
            end
            if (cmd.evict)
            begin
                if (any_reg)
                begin
                    loaded_reg[vp_reg]   <= 1'b0;
                    modified_reg[vp_reg] <= 1'b0;
                end
                loaded_reg[pg_reg]   <= 1'b1;
                modified_reg[pg_reg] <= 1'b0;
            end
            if (cmd.update && op_reg == OP_WRITE && perm_ok)
            begin
                modified_reg[pg_reg] <= 1'b1;
            end
            if (cmd.scan_init)
            begin
                scan_cnt_reg <= '0;
                cmp_vld_reg  <= 1'b0;
                any_reg      <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (scan_issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    cmp_vld_reg  <= 1'b1;
                end
                else
                begin
                    cmp_vld_reg <= 1'b0;
                end
                if (cmp_vld_reg && take)
                begin
                    any_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            va_reg    <= virtual_address;
            pid_reg   <= process_id;
            fault_reg <= 1'b0;
            repl_reg  <= 1'b0;
            wb_reg    <= 1'b0;
            victim_reg <= '0;
        end
        if (cmd.mul)
        begin
            prod_reg <= {32'b0, va_reg} * {{VA_W{1'b0}}, RECIP};
        end
        if (cmd.qd)
        begin
            q0_reg <= prod_reg[PROD_W-1:32];
            qd_reg <= prod_reg[PROD_W-1:32] * PB16;
        end
        if (cmd.divide)
        begin
            oob_reg <= ({3'b0, va_reg} >= VSIZE);
            if (rem0 >= PB16)
            begin
                pg_reg  <= PG_IW'(q0_reg + 1'b1);
                off_reg <= OFF_W'(rem0 - PB16);
            end
            else
            begin
                pg_reg  <= PG_IW'(q0_reg);
                off_reg <= OFF_W'(rem0);
            end
        end
        if (cmd.scan_step)
        begin
            if (scan_issue)
            begin
                cmp_idx_reg <= PG_IW'(scan_cnt_reg);
            end
            if (cmp_vld_reg && take)
            begin
                best_cnt_reg   <= rd_count;
                best_frame_reg <= rd_frame;
                vp_reg         <= cmp_idx_reg;
            end
        end
        if (cmd.hit_load)
        begin
            frame_reg <= rd_frame;
            count_reg <= rd_count;
        end
        if (cmd.alloc)
        begin
            frame_reg <= alloc_frame;
            count_reg <= '0;
            fault_reg <= 1'b1;
        end
        if (cmd.evict)
        begin
            frame_reg  <= evict_frame;
            count_reg  <= '0;
            fault_reg  <= 1'b1;
            repl_reg   <= any_reg;
            wb_reg     <= any_reg && modified_reg[vp_reg];
            victim_reg <= any_reg ? vp_reg : '0;
        end
        if (cmd.deny)
        begin
            status_reg       <= oob_reg ? ST_OOB : ST_PROC;
            phys_reg         <= '0;
            page_fault_reg   <= 1'b0;
            replaced_reg     <= 1'b0;
            victim_page_reg  <= '0;
            writeback_reg    <= 1'b0;
            frame_number_reg <= '0;
        end
        if (cmd.update)
        begin
            status_reg       <= upd_status;
            phys_reg         <= phys_full[PA_W-1:0];
            page_fault_reg   <= fault_reg;
            replaced_reg     <= repl_reg;
            victim_page_reg  <= PAGE_W'(victim_reg);
            writeback_reg    <= wb_reg;
            frame_number_reg <= frame_ext[FN_W-1:0];
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign physical_address = phys_reg;
    assign page_fault       = page_fault_reg;
    assign replaced         = replaced_reg;
    assign victim_page      = victim_page_reg;
    assign writeback        = writeback_reg;
    assign frame_number     = frame_number_reg;

endmodule

FILE: rtl/core/ptl_checker.sv
// ----------------------------------------------------------------------------
// ptl_checker
// Port-level checks of the translation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptl_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [ptl_pkg::ST_W-1:0]      status,
    input logic [ptl_pkg::PA_W-1:0]      physical_address,
    input logic                          page_fault,
    input logic                          replaced,
    input logic [ptl_pkg::PAGE_W-1:0]    victim_page,
    input logic                          writeback,
    input logic [ptl_pkg::FN_W-1:0]      frame_number
);
    import ptl_pkg::*;

    // result comes out as the block returns to idle
    `ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    // an accepted request keeps the block busy in the next cycle
    `ASSERT_NXT(a_req_busy, clk, rst_n, start && !busy, busy)

    // one strobe per request, never two in a row
    `ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)

    // rejected requests carry an all-zero translation
    `ASSERT_IMP(a_reject_zero, clk, rst_n, done && (status == ST_OOB || status == ST_PROC),
        !page_fault && !replaced && frame_number == '0 && physical_address == '0)

    // no eviction, no victim and no writeback
    `ASSERT_IMP(a_no_victim, clk, rst_n, done && !replaced, !writeback && victim_page == '0)

endmodule

bind paged_translation_lfu_top ptl_checker u_ptl_checker (.*);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged translation block with LFU replacement.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own page table, frame map, use counters and masks.
// It computes the expected translation of every request the block takes and
// compares each done pulse against the oldest prediction. The run covers
// directed corners, a run of hits on one page to lift its counter above the
// rest, and random phases under several mask settings and sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptl_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [PA_W-1:0]   phys_addr;
        logic              fault;
        logic              replaced;
        logic [PAGE_W-1:0] victim;
        logic              writeback;
        logic [FN_W-1:0]   frame;
    } xlate_result_t;

    class mmu_scoreboard;
        localparam int PAGES  = 64;
        localparam int FRAMES = 16;
        localparam logic [VA_W-1:0] VIRT_BYTES = 16'd1024;

        logic [CFG_W-1:0]   proc_mask [4];
        logic [CFG_W-1:0]   read_ok;
        logic [CFG_W-1:0]   write_ok;
        logic [CFG_W-1:0]   exec_ok;
        logic [FN_W-1:0]    frame_of [PAGES];
        bit                 loaded [PAGES];
        bit                 dirty [PAGES];
        logic [CNT_W-1:0]   uses [PAGES];
        bit                 frame_taken [FRAMES];
        xlate_result_t      expected_q [$];
        int                 errors;

        function new();
            foreach (proc_mask[i])
                proc_mask[i] = '1;
            read_ok  = '1;
            write_ok = '1;
            exec_ok  = '1;
            foreach (loaded[i])
            begin
                frame_of[i] = '0;
                loaded[i]   = 1'b0;
                dirty[i]    = 1'b0;
                uses[i]     = '0;
            end
            foreach (frame_taken[i])
                frame_taken[i] = 1'b0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_READABLE:   read_ok  = value;
                REG_WRITABLE:   write_ok = value;
                REG_EXECUTABLE: exec_ok  = value;
                default:        proc_mask[idx[1:0]] = value;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void place_page(logic [PAGE_W-1:0] pg, int frame);
            frame_of[pg]       = FN_W'(frame);
            loaded[pg]         = 1'b1;
            dirty[pg]          = 1'b0;
            uses[pg]           = '0;
            frame_taken[frame] = 1'b1;
        endfunction

        function xlate_result_t translate(logic [OP_W-1:0] op, logic [VA_W-1:0] va,
                                          logic [PID_W-1:0] pid);
            xlate_result_t r;
            logic [PAGE_W-1:0] pg;
            logic [3:0]        off;
            logic [CFG_W-1:0]  perm;
            int                free_frame;
            int                lfu_page;
            int                lfu_count;
            r = '0;
            if (va >= VIRT_BYTES)
            begin
                r.status = ST_OOB;
                return r;
            end
            pg  = va[9:4];
            off = va[3:0];
            if (!proc_mask[pid][pg])
            begin
                r.status = ST_PROC;
                return r;
            end
            if (!loaded[pg])
            begin
                r.fault    = 1'b1;
                free_frame = -1;
                for (int f = 0; f < FRAMES; f++)
                    if (free_frame < 0 && !frame_taken[f])
                        free_frame = f;
                if (free_frame >= 0)
                    place_page(pg, free_frame);
                else
                begin
                    // least used loaded page, lowest page number on ties
                    lfu_page  = 0;
                    lfu_count = 32'h7FFF_FFFF;
                    for (int p = 0; p < PAGES; p++)
                        if (loaded[p] && int'(uses[p]) < lfu_count)
                        begin
                            lfu_count = int'(uses[p]);
                            lfu_page  = p;
                        end
                    r.replaced  = 1'b1;
                    r.victim    = PAGE_W'(lfu_page);
                    r.writeback = dirty[lfu_page];
                    loaded[lfu_page] = 1'b0;
                    dirty[lfu_page]  = 1'b0;
                    uses[lfu_page]   = '0;
                    place_page(pg, int'(frame_of[lfu_page]));
                end
            end
            r.frame     = frame_of[pg];
            r.phys_addr = {frame_of[pg], off};
            if (op == OP_INVALID)
                r.status = ST_INVALID;
            else
            begin
                if (uses[pg] != '1)
                    uses[pg] = uses[pg] + 1'b1;
                perm = (op == OP_READ) ? read_ok : (op == OP_WRITE) ? write_ok : exec_ok;
                if (!perm[pg])
                    r.status = (op == OP_READ) ? ST_RD_DENY :
                               (op == OP_WRITE) ? ST_WR_DENY : ST_EX_DENY;
                else if (op == OP_WRITE)
                    dirty[pg] = 1'b1;
            end
            return r;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [VA_W-1:0] va,
                                   logic [PID_W-1:0] pid);
            expected_q.push_back(translate(op, va, pid));
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(xlate_result_t got);
            xlate_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding: status %0d, phys %0d",
                       got.status, got.phys_addr);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("status", 8'(want.status), 8'(got.status));
            check_field("physical_address", want.phys_addr, got.phys_addr);
            check_field("page_fault", 8'(want.fault), 8'(got.fault));
            check_field("replaced", 8'(want.replaced), 8'(got.replaced));
            check_field("victim_page", 8'(want.victim), 8'(got.victim));
            check_field("writeback", 8'(want.writeback), 8'(got.writeback));
            check_field("frame_number", 8'(want.frame), 8'(got.frame));
        endfunction
    endclass

    typedef enum int {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} idle_mode_e;

    localparam logic [CFG_IDX_W-1:0] REG_PROC0 = 3'd0;
    localparam int NUM_PHASES  = 7;
    localparam int SOAK_HITS   = 30;
    localparam logic [PAGE_W-1:0] SOAK_PAGE = 6'd10;
    localparam int DRAIN_TAIL  = 80;
    localparam int unsigned LIMIT = 3_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      opcode = '0;
    logic [VA_W-1:0]      virtual_address = '0;
    logic [PID_W-1:0]     process_id = '0;
    logic [WBYTE_W-1:0]   write_byte = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 done;
    logic [ST_W-1:0]      status;
    logic [PA_W-1:0]      physical_address;
    logic                 page_fault;
    logic                 replaced;
    logic [PAGE_W-1:0]    victim_page;
    logic                 writeback;
    logic [FN_W-1:0]      frame_number;

    mmu_scoreboard sb = new();
    int unsigned   cycle_count = 0;

    paged_translation_lfu_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .virtual_address  (virtual_address),
        .process_id       (process_id),
        .write_byte       (write_byte),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .status           (status),
        .physical_address (physical_address),
        .page_fault       (page_fault),
        .replaced         (replaced),
        .victim_page      (victim_page),
        .writeback        (writeback),
        .frame_number     (frame_number)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({status, physical_address, page_fault, replaced,
                             victim_page, writeback, frame_number});
    end

    function automatic logic [VA_W-1:0] page_va(logic [PAGE_W-1:0] pg, logic [3:0] off);
        return {6'd0, pg, off};
    endfunction

    function automatic logic [CFG_W-1:0] wide_rand();
        return {$urandom, $urandom};
    endfunction

    // roughly one bit in eight cleared
    function automatic logic [CFG_W-1:0] dense_mask();
        return ~(wide_rand() & wide_rand() & wide_rand());
    endfunction

    // called at a rising edge; returns at the edge that takes the request
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
                                 input logic [PID_W-1:0] pid,
                                 input logic [WBYTE_W-1:0] data);
        start           <= 1'b1;
        opcode          <= op;
        virtual_address <= va;
        process_id      <= pid;
        write_byte      <= data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(op, va, pid);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic pause(input int cycles, input bit drain);
        start <= 1'b0;
        if (drain)
            wait_drained();
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic load_masks(input logic [CFG_W-1:0] masks [NUM_CFG]);
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= masks[i];
            sb.set_register(CFG_IDX_W'(i), masks[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic apply_phase(input int ph);
        logic [CFG_W-1:0] m [NUM_CFG];
        foreach (m[i])
            m[i] = '1;
        case (ph)
            1:
            begin
                foreach (m[i])
                    m[i] = dense_mask();
            end
            2:
            begin
                for (int k = 0; k < 4; k++)
                    m[REG_PROC0 + k] = dense_mask();
                m[REG_READABLE]   = wide_rand();
                m[REG_WRITABLE]   = wide_rand();
                m[REG_EXECUTABLE] = wide_rand();
            end
            3:
            begin
                m[REG_READABLE]   = '0;
                m[REG_WRITABLE]   = '0;
                m[REG_EXECUTABLE] = '0;
            end
            4:
            begin
                m[REG_PROC0]      = '0;
                m[REG_PROC0 + 2]  = '0;
                m[REG_PROC0 + 3]  = dense_mask();
                m[REG_READABLE]   = dense_mask();
                m[REG_WRITABLE]   = dense_mask();
                m[REG_EXECUTABLE] = dense_mask();
            end
            5:
            begin
                foreach (m[i])
                    m[i] = '0;
            end
            default:
            begin
            end
        endcase
        load_masks(m);
    endtask

    // mostly a hot set a bit wider than the frame pool, some anywhere, some OOB
    task automatic random_request(input logic [PAGE_W-1:0] hot_base);
        logic [OP_W-1:0]   op;
        logic [VA_W-1:0]   va;
        logic [PAGE_W-1:0] pg;
        int                pick;
        op   = ($urandom_range(0, 15) == 0) ? OP_INVALID : OP_W'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        pg   = (pick < 80) ? hot_base + PAGE_W'($urandom_range(0, 21))
                           : PAGE_W'($urandom_range(0, 63));
        va   = (pick >= 92) ? VA_W'($urandom_range(1024, 65535))
                            : page_va(pg, 4'($urandom));
        issue_request(op, va, PID_W'($urandom), WBYTE_W'($urandom));
    endtask

    initial
    begin
        int               count;
        int               gap;
        bit               drain;
        logic [PAGE_W-1:0] hot_base;
        idle_mode_e       mode;
        int               phase_items [NUM_PHASES];
        idle_mode_e       phase_idle [NUM_PHASES];

        phase_items = '{125, 125, 125, 125, 125, 50, 125};
        phase_idle  = '{IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT, IDLE_NONE,
                        IDLE_HEAVY, IDLE_LIGHT, IDLE_HEAVY};

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, fill all frames, then evict clean and dirty pages
        issue_request(OP_WRITE, page_va(6'd0, 4'd0), 2'd0, 8'hFF);
        issue_request(OP_READ, page_va(6'd63, 4'd15), 2'd3, 8'h00);
        issue_request(OP_READ, 16'h0400, 2'd1, 8'hA5);
        issue_request(OP_EXEC, 16'hFFFF, 2'd2, 8'h5A);
        issue_request(OP_EXEC, page_va(6'd5, 4'd5), 2'd1, 8'h0F);
        issue_request(OP_INVALID, page_va(6'd7, 4'd0), 2'd2, 8'hF0);
        for (int p = 10; p < 22; p++)
            issue_request(OP_READ, page_va(PAGE_W'(p), 4'(p)), PID_W'(p), WBYTE_W'(p));
        issue_request(OP_READ, page_va(6'd30, 4'd1), 2'd0, 8'h11);
        issue_request(OP_WRITE, page_va(6'd31, 4'd2), 2'd1, 8'h22);
        issue_request(OP_READ, page_va(6'd0, 4'd8), 2'd2, 8'h33);
        issue_request(OP_INVALID, 16'hFFFF, 2'd3, 8'h44);
        pause(0, 1'b1);

        // run of hits on one page so its counter stands well above the rest
        for (int n = 0; n < SOAK_HITS; n++)
            issue_request(OP_READ, page_va(SOAK_PAGE, 4'($urandom)), PID_W'($urandom),
                          WBYTE_W'($urandom));
        pause(0, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            apply_phase(ph);
            hot_base = PAGE_W'($urandom);
            mode     = phase_idle[ph];
            count    = phase_items[ph];
            for (int n = 0; n < count; n++)
            begin
                random_request(hot_base);
                gap = 0;
                if ((n / 40) % 3 != 2)
                begin
                    if (mode == IDLE_HEAVY && $urandom_range(0, 99) < 46)
                        gap = $urandom_range(1, 8);
                    else if (mode == IDLE_LIGHT && $urandom_range(0, 99) < 7)
                        gap = $urandom_range(1, 8);
                end
                // hold off now and then until every request has returned
                drain = (n == count - 1) || ($urandom_range(0, 49) == 0);
                if (gap > 0 || drain)
                    pause(gap, drain);
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
